### src/isb_pkg.sv
// Shared types, constants and helper functions for the integer-scaled pixel blit unit.
`timescale 1ns / 1ps

package isb_pkg;

    localparam int ADDR_BITS_DEF = 20;
    localparam int MAX_SCALE_DEF = 8;

    localparam int ADDR_W     = 20;
    localparam int COLOR_W    = 8;
    localparam int DIM_W      = 11;
    localparam int SCALE_W    = 4;
    localparam int POS_W      = 12;
    localparam int PITCH_W    = 13;
    localparam int CNT_W      = 10;
    localparam int YBASE_W    = 14;
    localparam int PROD_W     = YBASE_W + PITCH_W;
    localparam int FIFO_DEPTH = 4;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam int DIM_LIMIT  = 1024;

    typedef enum logic [2:0] {
        REG_RECT_WIDTH   = 3'd0,
        REG_RECT_HEIGHT  = 3'd1,
        REG_SCALE_FACTOR = 3'd2,
        REG_DEST_X       = 3'd3,
        REG_DEST_Y       = 3'd4,
        REG_DEST_PITCH   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]   rect_width;
        logic [DIM_W-1:0]   rect_height;
        logic [SCALE_W-1:0] scale_factor;
        logic [POS_W-1:0]   dest_x;
        logic [POS_W-1:0]   dest_y;
        logic [PITCH_W-1:0] dest_pitch;
    } t_cfg;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [ADDR_W-1:0]  line;
        logic [ADDR_W-1:0]  xbase;
        logic               last_rect;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(DIM_LIMIT)) begin
            r = DIM_W'(DIM_LIMIT);
        end
        return r;
    endfunction

    function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v,
                                                       input int max_scale);
        logic [SCALE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SCALE_W'(1);
        end else if (v > SCALE_W'(max_scale)) begin
            r = SCALE_W'(max_scale);
        end
        return r;
    endfunction

endpackage

### src/isb_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module isb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [isb_pkg::PADDR_W-1:0]   paddr,
    input  logic [isb_pkg::PDATA_W-1:0]   pwdata,
    output logic [isb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output isb_pkg::t_cfg                 o_cfg
);

    isb_pkg::t_cfg r_cfg;
    isb_pkg::t_reg_idx idx;
    logic wr_en;

    assign idx    = isb_pkg::t_reg_idx'(paddr[isb_pkg::PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rect_width   <= isb_pkg::DIM_W'(1);
            r_cfg.rect_height  <= isb_pkg::DIM_W'(1);
            r_cfg.scale_factor <= isb_pkg::SCALE_W'(1);
            r_cfg.dest_x       <= '0;
            r_cfg.dest_y       <= '0;
            r_cfg.dest_pitch   <= isb_pkg::PITCH_W'(320);
        end else if (wr_en) begin
            case (idx)
                isb_pkg::REG_RECT_WIDTH: begin
                    r_cfg.rect_width <= pwdata[isb_pkg::DIM_W-1:0];
                end
                isb_pkg::REG_RECT_HEIGHT: begin
                    r_cfg.rect_height <= pwdata[isb_pkg::DIM_W-1:0];
                end
                isb_pkg::REG_SCALE_FACTOR: begin
                    r_cfg.scale_factor <= pwdata[isb_pkg::SCALE_W-1:0];
                end
                isb_pkg::REG_DEST_X: begin
                    r_cfg.dest_x <= pwdata[isb_pkg::POS_W-1:0];
                end
                isb_pkg::REG_DEST_Y: begin
                    r_cfg.dest_y <= pwdata[isb_pkg::POS_W-1:0];
                end
                isb_pkg::REG_DEST_PITCH: begin
                    r_cfg.dest_pitch <= pwdata[isb_pkg::PITCH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            isb_pkg::REG_RECT_WIDTH:   prdata = isb_pkg::PDATA_W'(r_cfg.rect_width);
            isb_pkg::REG_RECT_HEIGHT:  prdata = isb_pkg::PDATA_W'(r_cfg.rect_height);
            isb_pkg::REG_SCALE_FACTOR: prdata = isb_pkg::PDATA_W'(r_cfg.scale_factor);
            isb_pkg::REG_DEST_X:       prdata = isb_pkg::PDATA_W'(r_cfg.dest_x);
            isb_pkg::REG_DEST_Y:       prdata = isb_pkg::PDATA_W'(r_cfg.dest_y);
            isb_pkg::REG_DEST_PITCH:   prdata = isb_pkg::PDATA_W'(r_cfg.dest_pitch);
            default:                   prdata = '0;
        endcase
    end

endmodule

### src/isb_front.sv
// Front end: accepts source pixels, tracks column and row, and builds per-pixel jobs.
`timescale 1ns / 1ps

module isb_front #(
    parameter int MAX_SCALE = isb_pkg::MAX_SCALE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  isb_pkg::t_cfg                 i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [isb_pkg::COLOR_W-1:0]   i_pixel_color,
    output logic                          o_push,
    output isb_pkg::t_job                 o_job,
    input  isb_pkg::t_fifo_stat           i_fifo_stat
);

    logic [isb_pkg::CNT_W-1:0]   r_col;
    logic [isb_pkg::CNT_W-1:0]   r_row;
    logic                        r_valid_a;
    logic [isb_pkg::COLOR_W-1:0] r_color;
    logic [isb_pkg::YBASE_W-1:0] r_ybase;
    logic [isb_pkg::ADDR_W-1:0]  r_xbase;
    logic                        r_last;

    logic [isb_pkg::DIM_W-1:0]   w;
    logic [isb_pkg::DIM_W-1:0]   h;
    logic [isb_pkg::SCALE_W-1:0] s;
    logic                        last_col;
    logic                        last_row;
    logic                        accept;
    logic [isb_pkg::YBASE_W-1:0] n_ybase;
    logic [isb_pkg::ADDR_W-1:0]  n_xbase;
    logic [isb_pkg::PROD_W-1:0]  line_prod;

    assign w        = isb_pkg::clamp_dim(i_cfg.rect_width);
    assign h        = isb_pkg::clamp_dim(i_cfg.rect_height);
    assign s        = isb_pkg::clamp_scale(i_cfg.scale_factor, MAX_SCALE);
    assign last_col = isb_pkg::DIM_W'(r_col) >= (w - isb_pkg::DIM_W'(1));
    assign last_row = isb_pkg::DIM_W'(r_row) >= (h - isb_pkg::DIM_W'(1));

    assign o_push     = r_valid_a && !i_fifo_stat.full;
    assign o_in_ready = !r_valid_a || o_push;
    assign accept     = i_in_valid && o_in_ready;

    assign n_ybase = isb_pkg::YBASE_W'(i_cfg.dest_y)
                   + isb_pkg::YBASE_W'(r_row) * isb_pkg::YBASE_W'(s);
    assign n_xbase = isb_pkg::ADDR_W'(i_cfg.dest_x)
                   + isb_pkg::ADDR_W'(r_col) * isb_pkg::ADDR_W'(s);

    assign line_prod = isb_pkg::PROD_W'(r_ybase) * isb_pkg::PROD_W'(i_cfg.dest_pitch);

    assign o_job.color     = r_color;
    assign o_job.line      = line_prod[isb_pkg::ADDR_W-1:0];
    assign o_job.xbase     = r_xbase;
    assign o_job.last_rect = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_valid_a <= 1'b0;
        end else begin
            if (accept) begin
                r_valid_a <= 1'b1;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + isb_pkg::CNT_W'(1);
                end else begin
                    r_col <= r_col + isb_pkg::CNT_W'(1);
                end
            end else if (o_push) begin
                r_valid_a <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_color <= i_pixel_color;
            r_ybase <= n_ybase;
            r_xbase <= n_xbase;
            r_last  <= last_col && last_row;
        end
    end

endmodule

### src/isb_fifo.sv
// Short job queue between the front end and the write generator.
`timescale 1ns / 1ps

module isb_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  isb_pkg::t_job       i_job,
    input  logic                i_pop,
    output isb_pkg::t_job       o_job,
    output isb_pkg::t_fifo_stat o_stat
);

    localparam int PTR_W = $clog2(isb_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(isb_pkg::FIFO_DEPTH + 1);

    isb_pkg::t_job    r_mem [isb_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_stat.full  = r_count == CNT_W'(isb_pkg::FIFO_DEPTH);
    assign o_stat.empty = r_count == '0;
    assign o_job        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

### src/isb_back.sv
// Back end: walks the scale-by-scale block of one job and issues one write per cycle while the output is ready.
`timescale 1ns / 1ps

module isb_back #(
    parameter int ADDR_BITS = isb_pkg::ADDR_BITS_DEF,
    parameter int MAX_SCALE = isb_pkg::MAX_SCALE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  isb_pkg::t_cfg                 i_cfg,
    input  isb_pkg::t_job                 i_job,
    input  isb_pkg::t_fifo_stat           i_fifo_stat,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [isb_pkg::ADDR_W-1:0]    o_write_address,
    output logic [isb_pkg::COLOR_W-1:0]   o_write_color,
    output logic                          o_last_of_pixel,
    output logic                          o_last_of_rect
);

    localparam int AW = (ADDR_BITS < isb_pkg::ADDR_W) ? ADDR_BITS : isb_pkg::ADDR_W;
    localparam logic [isb_pkg::ADDR_W-1:0] AMASK = isb_pkg::ADDR_W'((64'd1 << AW) - 64'd1);

    logic                        r_busy;
    logic [isb_pkg::SCALE_W-1:0] r_m;
    logic [isb_pkg::SCALE_W-1:0] r_n;
    logic [isb_pkg::ADDR_W-1:0]  r_line;
    logic [isb_pkg::ADDR_W-1:0]  r_x;
    logic [isb_pkg::ADDR_W-1:0]  r_xbase;
    logic [isb_pkg::COLOR_W-1:0] r_color;
    logic                        r_rlast;

    logic [isb_pkg::SCALE_W-1:0] s_last;
    logic                        out_adv;
    logic                        emit;
    logic                        pix_end;
    logic [isb_pkg::ADDR_W-1:0]  n_addr;

    assign s_last  = isb_pkg::clamp_scale(i_cfg.scale_factor, MAX_SCALE)
                   - isb_pkg::SCALE_W'(1);
    assign out_adv = !o_out_valid || i_out_ready;
    assign emit    = r_busy && out_adv;
    assign pix_end = (r_m == s_last) && (r_n == s_last);
    assign o_pop   = !i_fifo_stat.empty && (!r_busy || (emit && pix_end));
    assign n_addr  = (r_line + r_x) & AMASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && pix_end) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_m     <= '0;
            r_n     <= '0;
            r_line  <= i_job.line;
            r_x     <= i_job.xbase;
            r_xbase <= i_job.xbase;
            r_color <= i_job.color;
            r_rlast <= i_job.last_rect;
        end else if (emit) begin
            if (r_n == s_last) begin
                r_n    <= '0;
                r_m    <= r_m + isb_pkg::SCALE_W'(1);
                r_x    <= r_xbase;
                r_line <= r_line + isb_pkg::ADDR_W'(i_cfg.dest_pitch);
            end else begin
                r_n <= r_n + isb_pkg::SCALE_W'(1);
                r_x <= r_x + isb_pkg::ADDR_W'(1);
            end
        end
        if (emit) begin
            o_write_address <= n_addr;
            o_write_color   <= r_color;
            o_last_of_pixel <= pix_end;
            o_last_of_rect  <= pix_end && r_rlast;
        end
    end

endmodule

### src/integer_scaled_pixel_blit_unit.sv
// A pixel is registered in the front end, queued, then loaded into the write generator.
// Each pixel gives scale*scale writes (1 to 64); one write per cycle while output is ready.
// The front end takes a new pixel each cycle while the 4-entry job queue has room.
// Reset is synchronous and active low: counters and queue clear, registers take defaults.
// Top level of the integer-scaled pixel blit unit.
`timescale 1ns / 1ps

module integer_scaled_pixel_blit_unit #(
    parameter int ADDR_BITS = isb_pkg::ADDR_BITS_DEF,
    parameter int MAX_SCALE = isb_pkg::MAX_SCALE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [isb_pkg::PADDR_W-1:0]   paddr,
    input  logic [isb_pkg::PDATA_W-1:0]   pwdata,
    output logic [isb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [isb_pkg::COLOR_W-1:0]   i_pixel_color,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [isb_pkg::ADDR_W-1:0]    o_write_address,
    output logic [isb_pkg::COLOR_W-1:0]   o_write_color,
    output logic                          o_last_of_pixel,
    output logic                          o_last_of_rect
);

    isb_pkg::t_cfg       cfg;
    isb_pkg::t_job       push_job;
    isb_pkg::t_job       head_job;
    isb_pkg::t_fifo_stat fifo_stat;
    logic                push;
    logic                pop;

    isb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    isb_front #(
        .MAX_SCALE (MAX_SCALE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel_color (i_pixel_color),
        .o_push        (push),
        .o_job         (push_job),
        .i_fifo_stat   (fifo_stat)
    );

    isb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (fifo_stat)
    );

    isb_back #(
        .ADDR_BITS (ADDR_BITS),
        .MAX_SCALE (MAX_SCALE)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_job           (head_job),
        .i_fifo_stat     (fifo_stat),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_write_address (o_write_address),
        .o_write_color   (o_write_color),
        .o_last_of_pixel (o_last_of_pixel),
        .o_last_of_rect  (o_last_of_rect)
    );

`ifndef SYNTHESIS
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_stat.full && fifo_stat.empty))
        else $error("Job queue reports full and empty at once.");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_stat.full |-> !push || pop)
        else $error("Job pushed into a full queue.");

    a_rect_end_is_pixel_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_rect |-> o_last_of_pixel)
        else $error("Rectangle end flagged on a write that does not end its pixel.");

    a_reset_clears_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("Output valid after reset.");
`endif

endmodule
